// ===== rtl/symmetric_coo_sparse_matvec_assert.svh =====
// Assertion macros for the symmetric COO sparse mat-vec block.
// Used by the top level; needs clk_i and rst_ni in the including scope.
`ifndef SYMMETRIC_COO_SPARSE_MATVEC_ASSERT_SVH
`define SYMMETRIC_COO_SPARSE_MATVEC_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SCSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SCSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SCSM_ASSERT(lbl, prop, msg)
`define SCSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/scsm_pkg.sv =====
// Shared types and constants for the symmetric COO sparse mat-vec block.
// No dependencies; imported by the controller, datapath and top level.
package scsm_pkg;

  localparam int unsigned DIM_W       = 7;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned PROD_W      = 2 * VAL_W;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned DEF_MAX_DIM = 64;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam logic [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_NZ   = 2'd1,
    KIND_EMIT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_ADD_A,
    ST_ADD_B,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef enum logic [1:0] {
    RD_ROW,
    RD_COL,
    RD_EMIT
  } rd_sel_e;

  typedef struct packed {
    logic    accept;     // latch fields, read vector store
    logic    vec_wr;
    logic    mul_en;
    logic    mul_sel_xa; // 0: value*x[col], 1: value*x[row]
    logic    acc_rd_en;
    rd_sel_e acc_rd_sel;
    logic    acc_wr_en;
    logic    acc_wr_col; // 0: write row entry, 1: column entry
    logic    emit_ld;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  ld_ok;
    logic  nz_ok;
    logic  same;
    logic  last;
    logic  out_free;
  } stat_t;

endpackage

// ===== rtl/scsm_ctrl.sv =====
// Sequencer for the symmetric COO sparse mat-vec block.
// Depends on scsm_pkg; drives scsm_dp through cmd_t, reads stat_t.
module scsm_ctrl
  import scsm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (stat_i.kind)
            KIND_NZ:   if (stat_i.nz_ok) state_d = ST_MUL_A;
            KIND_EMIT: state_d = ST_EMIT_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL_A:   state_d = ST_ADD_A;
      ST_ADD_A:   state_d = stat_i.same ? ST_IDLE : ST_ADD_B;
      ST_ADD_B:   state_d = ST_IDLE;
      ST_EMIT_RD: state_d = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (stat_i.out_free) state_d = stat_i.last ? ST_IDLE : ST_EMIT_RD;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.acc_rd_sel = RD_ROW;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        cmd_o.vec_wr = in_valid_i && (stat_i.kind == KIND_LOAD) && stat_i.ld_ok;
      end
      ST_MUL_A: begin
        cmd_o.mul_en     = 1'b1;
        cmd_o.acc_rd_en  = 1'b1;
        cmd_o.acc_rd_sel = RD_ROW;
      end
      ST_ADD_A: begin
        // row update retires while the column product and read go ahead
        cmd_o.acc_wr_en  = 1'b1;
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel_xa = 1'b1;
        cmd_o.acc_rd_en  = 1'b1;
        cmd_o.acc_rd_sel = RD_COL;
      end
      ST_ADD_B: begin
        cmd_o.acc_wr_en  = 1'b1;
        cmd_o.acc_wr_col = 1'b1;
      end
      ST_EMIT_RD: begin
        cmd_o.acc_rd_en  = 1'b1;
        cmd_o.acc_rd_sel = RD_EMIT;
      end
      ST_EMIT_LD: begin
        cmd_o.emit_ld = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/scsm_dp.sv =====
// Datapath of the symmetric COO sparse mat-vec block: vector and accumulator
// stores, multiplier, saturating adder, output register. Depends on scsm_pkg.
module scsm_dp
  import scsm_pkg::*;
#(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [DIM_W-1:0]       cfg_data_i,
  input  logic [KIND_W-1:0]      in_kind_i,
  input  logic [IDX_W-1:0]       in_index_a_i,
  input  logic [IDX_W-1:0]       in_index_b_i,
  input  logic [VAL_W-1:0]       in_value_i,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [IDX_W-1:0]       out_index_o,
  output logic [ACC_W-1:0]       out_value_o,
  output logic                   out_last_o
);

  localparam int unsigned AW = $clog2(MAX_DIM);
  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

  logic [DIM_W-1:0] dim_q;
  logic [DIM_W-1:0] dim_eff;

  logic [VAL_W-1:0] vec_mem [MAX_DIM];
  logic [ACC_W-1:0] acc_mem [MAX_DIM];
  logic [MAX_DIM-1:0] acc_vld_q;

  logic [IDX_W-1:0]        a_q, b_q;
  logic                    same_q;
  logic signed [VAL_W-1:0] val_q, xa_q, xb_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]        rdata_q;
  logic                    rvld_q;
  logic [AW-1:0]           k_q;

  logic [AW-1:0]           rd_addr, wr_addr;
  logic signed [ACC_W-1:0] acc_old, addend;
  logic signed [ACC_W:0]   sum_w;
  logic [ACC_W-1:0]        sum_sat;
  logic                    last;

  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_index_q;
  logic [ACC_W-1:0]        out_value_q;
  logic                    out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RESET;
    end else if (cfg_valid_i) begin
      dim_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (dim_q == '0) begin
      dim_eff = DIM_W'(1);
    end else if (dim_q > MAX_DIM_V) begin
      dim_eff = MAX_DIM_V;
    end else begin
      dim_eff = dim_q;
    end
  end

  assign last = ((DIM_W'(k_q) + DIM_W'(1)) == dim_eff);

  always_comb begin
    stat_o.kind     = kind_e'(in_kind_i);
    stat_o.ld_ok    = {1'b0, in_index_a_i} < dim_eff;
    stat_o.nz_ok    = ({1'b0, in_index_a_i} < dim_eff) && ({1'b0, in_index_b_i} < dim_eff);
    stat_o.same     = same_q;
    stat_o.last     = last;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  // vector store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.vec_wr) begin
      vec_mem[in_index_a_i[AW-1:0]] <= in_value_i;
    end
    if (cmd_i.accept) begin
      xa_q   <= $signed(vec_mem[in_index_a_i[AW-1:0]]);
      xb_q   <= $signed(vec_mem[in_index_b_i[AW-1:0]]);
      a_q    <= in_index_a_i;
      b_q    <= in_index_b_i;
      val_q  <= $signed(in_value_i);
      same_q <= (in_index_a_i == in_index_b_i);
    end
    if (cmd_i.mul_en) begin
      prod_q <= val_q * (cmd_i.mul_sel_xa ? xa_q : xb_q);
    end
  end

  always_comb begin
    case (cmd_i.acc_rd_sel)
      RD_ROW:  rd_addr = a_q[AW-1:0];
      RD_COL:  rd_addr = b_q[AW-1:0];
      RD_EMIT: rd_addr = k_q;
      default: rd_addr = a_q[AW-1:0];
    endcase
  end

  assign wr_addr = cmd_i.acc_wr_col ? b_q[AW-1:0] : a_q[AW-1:0];

  // floor of the Q32.32 product to Q32.16, then 49-bit sum and clamp
  assign acc_old = rvld_q ? $signed(rdata_q) : '0;
  assign addend  = $signed(prod_q[PROD_W-1:FRAC_W]);
  assign sum_w   = {acc_old[ACC_W-1], acc_old} + {addend[ACC_W-1], addend};

  always_comb begin
    if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      sum_sat = sum_w[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_w[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_wr_en) begin
      acc_mem[wr_addr] <= sum_sat;
    end
    if (cmd_i.acc_rd_en) begin
      rdata_q <= acc_mem[rd_addr];
    end
  end

  // entries without a valid bit read as zero; emit drops them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
      rvld_q    <= 1'b0;
      k_q       <= '0;
    end else begin
      if (cmd_i.acc_rd_en) begin
        rvld_q <= acc_vld_q[rd_addr];
      end
      if (cmd_i.emit_ld && last) begin
        acc_vld_q <= '0;
      end else if (cmd_i.acc_wr_en) begin
        acc_vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.emit_ld) begin
        k_q <= last ? '0 : k_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      out_index_q <= IDX_W'(k_q);
      out_value_q <= rvld_q ? rdata_q : '0;
      out_last_q  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/symmetric_coo_sparse_matvec.sv =====
// Top level of the symmetric COO sparse mat-vec block (y = H*x, one triangle).
// Depends on scsm_pkg, scsm_ctrl, scsm_dp and the assertion macro header.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+----------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser kind, tdata a/b/value
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata index/value, tlast
//  cfg      | in  | cfg_valid_i/cfg_ready_o      | dimension (7 bits)
//
// Load item: written to the vector store as it is accepted. Nonzero: states MUL_A, ADD_A and
// ADD_B (ADD_B skipped on the diagonal), set by the single multiplier and the one read/one
// write port of the accumulator store. Emit: per element a registered accumulator read, then
// output load, stalled while the output register is held by m_axis_tready low.
// Reset clears all accumulator valid bits at once; there is no clearing pass.
// The vector store holds no reset value and must be loaded before use.
`include "symmetric_coo_sparse_matvec_assert.svh"

module symmetric_coo_sparse_matvec
  import scsm_pkg::*;
#(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // index_a[5:0] index_b[11:6] entry_value[43:12]
  input  logic [KIND_W-1:0]      s_axis_tuser,  // kind[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_index[5:0] out_value[53:6]
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [DIM_W-1:0]       cfg_data_i
);

  cmd_t             cmd;
  stat_t            stat;
  logic [IDX_W-1:0] out_index;
  logic [ACC_W-1:0] out_value;

  assign cfg_ready_o = 1'b1;

  scsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  scsm_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_kind_i    (s_axis_tuser),
    .in_index_a_i (s_axis_tdata[IDX_W-1:0]),
    .in_index_b_i (s_axis_tdata[2*IDX_W-1:IDX_W]),
    .in_value_i   (s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_index_o  (out_index),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-ACC_W-IDX_W){1'b0}}, out_value, out_index};

  // accumulator writes always consume a read issued the cycle before
  `SCSM_ASSERT(a_wr_after_rd, cmd.acc_wr_en |-> $past(cmd.acc_rd_en), "acc write without read")
  // every output load is preceded by its own read cycle
  `SCSM_ASSERT(a_ld_spaced, cmd.emit_ld |=> !cmd.emit_ld, "emit loads back to back")
  `SCSM_ASSERT(a_no_overrun, cmd.emit_ld |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
  `SCSM_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !m_axis_tvalid, "output valid in reset")

endmodule
